// File: rtl/rps_pkg.sv
// Shared constants and types for the radial power spectrum averager.
`timescale 1ns / 1ps
`default_nettype none
package rps_pkg;
    localparam int MAX_HALF_DEF   = 256;
    localparam int MAX_BINS_DEF   = 64;
    localparam int SAMPLE_W_DEF   = 16;
    localparam int COORD_W        = 9;
    localparam int FIELD_W        = 16;
    localparam int BIN_IDX_W      = 6;
    localparam int HALF_W         = 9;
    localparam int NBINS_W        = 7;
    localparam int SUM_W          = 49;
    localparam int CNT_W          = 17;
    localparam int AVG_W          = 32;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;
    localparam logic [HALF_W-1:0]  HALF_RESET = 9'd128;
    localparam logic [NBINS_W-1:0] BINS_RESET = 7'd64;

    typedef enum logic [0:0] {
        REG_HALF_SIZE = 1'b0,
        REG_BIN_COUNT = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT_GO,
        S_ROOT,
        S_MODIFY,
        S_EMIT_RD,
        S_EMIT_GO,
        S_EMIT_DIV,
        S_EMIT_OUT
    } t_state;
endpackage
`default_nettype wire

// File: rtl/rps_if.sv
// Stream channel interfaces for samples in and bin results out.
`timescale 1ns / 1ps
`default_nettype none
interface rps_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [rps_pkg::COORD_W-1:0]          row;
    logic [rps_pkg::COORD_W-1:0]          col;
    logic signed [rps_pkg::FIELD_W-1:0]   real_part;
    logic signed [rps_pkg::FIELD_W-1:0]   imag_part;
    logic                                 last_sample;
    modport source(output valid, row, col, real_part, imag_part, last_sample, input ready);
    modport sink(input valid, row, col, real_part, imag_part, last_sample, output ready);
endinterface

interface rps_out_if;
    logic                           valid;
    logic                           ready;
    logic [rps_pkg::BIN_IDX_W-1:0]  bin_index;
    logic [rps_pkg::AVG_W-1:0]      average_power;
    logic                           last_bin;
    logic                           overflow_seen;
    modport source(output valid, bin_index, average_power, last_bin, overflow_seen,
                   input ready);
    modport sink(input valid, bin_index, average_power, last_bin, overflow_seen,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/radial_power_spectrum_average.sv
// Top level: sample intake, bin store, per-frame emission and register port.
`timescale 1ns / 1ps
`default_nettype none
// Accumulates re^2+im^2 of FFT samples into radial bins floor(sqrt((row^2+col^2)/2))
// inside the half_size window, and on the sample flagged last_sample emits one
// average per bin in use, then clears the store. One sample at a time: a sample passes
// through intake, squaring, the bit-serial square root and a read-modify-write of the
// bin memory before the next is taken. Each emitted bin waits on the 49-step divider
// and on the sink. After reset and after each frame the store reads as zero with no
// clearing pass.
module radial_power_spectrum_average #(
    parameter int MAX_HALF     = rps_pkg::MAX_HALF_DEF,
    parameter int MAX_BINS     = rps_pkg::MAX_BINS_DEF,
    parameter int SAMPLE_WIDTH = rps_pkg::SAMPLE_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rps_in_if.sink                             i_samp,
    rps_out_if.source                          o_bins,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rps_pkg::APB_AW-1:0]    paddr,
    input  wire logic [rps_pkg::APB_DW-1:0]    pwdata,
    output logic [rps_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    localparam int CW  = $clog2(MAX_HALF);
    localparam int XW  = 2 * CW;
    localparam int BW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int PW  = 2 * SAMPLE_WIDTH;
    localparam int SW  = rps_pkg::SUM_W;
    localparam int NW  = rps_pkg::CNT_W;
    localparam int HW  = rps_pkg::HALF_W;
    localparam int NBW = rps_pkg::NBINS_W;

    rps_pkg::t_state r_state, n_state;

    logic [HW-1:0]  r_half;
    logic [NBW-1:0] r_nbins;
    logic [HW-1:0]  w_hs;
    logic [NBW-1:0] w_nb;

    logic [CW-1:0]  r_row, r_col;
    logic signed [SAMPLE_WIDTH-1:0] r_re, r_im;
    logic           r_last, r_win, r_ovf;
    logic [XW-1:0]  r_x;
    logic [PW-1:0]  r_pow;
    logic [BW-1:0]  r_bin, r_k;

    logic [SW+NW-1:0] mem [MAX_BINS];
    logic             r_vld [MAX_BINS];
    logic [SW+NW-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [SW-1:0]    w_sum;
    logic [NW-1:0]    w_cnt;
    logic [SW:0]      w_sum_add;
    logic [SW-1:0]    w_sum_new;
    logic [NW-1:0]    w_cnt_new;

    logic             w_rd_en, w_wr_en, w_root_go, w_div_go, w_clear;
    logic [BW-1:0]    w_rd_addr;
    logic             w_root_done, w_div_done;
    logic [CW-1:0]    w_root;
    logic [15:0]      w_root_ext;
    logic             w_root_out;
    logic [rps_pkg::AVG_W-1:0] w_quo;
    logic             w_last_k;

    logic [2*CW-1:0]  w_rr, w_cc;
    logic [2*CW:0]    w_r2;
    logic signed [PW-1:0] w_re2, w_im2;

    logic [rps_pkg::AVG_W-1:0] r_avg;
    logic             r_cnt_zero;

    assign w_hs = (r_half > HW'(MAX_HALF)) ? HW'(MAX_HALF) : r_half;
    assign w_nb = (r_nbins == '0) ? NBW'(1) :
                  ((r_nbins > NBW'(MAX_BINS)) ? NBW'(MAX_BINS) : r_nbins);

    // register port
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= rps_pkg::HALF_RESET;
            r_nbins <= rps_pkg::BINS_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (rps_pkg::t_reg_idx'(paddr[2]))
                rps_pkg::REG_HALF_SIZE: r_half  <= pwdata[HW-1:0];
                rps_pkg::REG_BIN_COUNT: r_nbins <= pwdata[NBW-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (rps_pkg::t_reg_idx'(paddr[2]))
            rps_pkg::REG_HALF_SIZE: prdata = {{(32-HW){1'b0}}, r_half};
            rps_pkg::REG_BIN_COUNT: prdata = {{(32-NBW){1'b0}}, r_nbins};
            default:                prdata = '0;
        endcase
    end

    // squares
    assign w_rr  = r_row * r_row;
    assign w_cc  = r_col * r_col;
    assign w_r2  = {1'b0, w_rr} + {1'b0, w_cc};
    assign w_re2 = r_re * r_re;
    assign w_im2 = r_im * r_im;

    rps_isqrt #(.ROOT_W(CW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_go),
        .i_x     (r_x),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    assign w_root_ext = 16'(w_root);
    assign w_root_out = ({7'd0, w_root_ext} >= {7'd0, 9'(w_nb), 7'd0} >> 7);

    // bin store
    assign w_sum     = r_rd_vld ? r_rd_data[SW+NW-1:NW] : '0;
    assign w_cnt     = r_rd_vld ? r_rd_data[NW-1:0] : '0;
    assign w_sum_add = {1'b0, w_sum} + (SW+1)'(r_pow);
    assign w_sum_new = w_sum_add[SW] ? '1 : w_sum_add[SW-1:0];
    assign w_cnt_new = (&w_cnt) ? w_cnt : w_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_bin] <= {w_sum_new, w_cnt_new};
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            for (int i = 0; i < MAX_BINS; i++) r_vld[i] <= 1'b0;
        end else if (w_wr_en) begin
            r_vld[r_bin] <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_vld <= r_vld[w_rd_addr];
        end
    end

    rps_divider #(.NUM_W(SW), .DEN_W(NW), .QUO_W(rps_pkg::AVG_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (w_sum),
        .i_den   (w_cnt),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_last_k = ((NBW'(r_k) + 1'b1) == w_nb);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        i_samp.ready = 1'b0;
        o_bins.valid = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_k;
        w_wr_en      = 1'b0;
        w_root_go    = 1'b0;
        w_div_go     = 1'b0;
        w_clear      = 1'b0;
        unique case (r_state)
            rps_pkg::S_IDLE: begin
                i_samp.ready = 1'b1;
                if (i_samp.valid) n_state = rps_pkg::S_SQUARE;
            end
            rps_pkg::S_SQUARE: begin
                n_state = r_win ? rps_pkg::S_ROOT_GO :
                          (r_last ? rps_pkg::S_EMIT_RD : rps_pkg::S_IDLE);
            end
            rps_pkg::S_ROOT_GO: begin
                w_root_go = 1'b1;
                n_state   = rps_pkg::S_ROOT;
            end
            rps_pkg::S_ROOT: begin
                if (w_root_done) begin
                    if (w_root_out) begin
                        n_state = r_last ? rps_pkg::S_EMIT_RD : rps_pkg::S_IDLE;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_root_ext[BW-1:0];
                        n_state   = rps_pkg::S_MODIFY;
                    end
                end
            end
            rps_pkg::S_MODIFY: begin
                w_wr_en = 1'b1;
                n_state = r_last ? rps_pkg::S_EMIT_RD : rps_pkg::S_IDLE;
            end
            rps_pkg::S_EMIT_RD: begin
                w_rd_en = 1'b1;
                n_state = rps_pkg::S_EMIT_GO;
            end
            rps_pkg::S_EMIT_GO: begin
                w_div_go = 1'b1;
                n_state  = rps_pkg::S_EMIT_DIV;
            end
            rps_pkg::S_EMIT_DIV: begin
                if (w_div_done) n_state = rps_pkg::S_EMIT_OUT;
            end
            rps_pkg::S_EMIT_OUT: begin
                o_bins.valid = 1'b1;
                if (o_bins.ready) begin
                    if (w_last_k) begin
                        w_clear = 1'b1;
                        n_state = rps_pkg::S_IDLE;
                    end else begin
                        n_state = rps_pkg::S_EMIT_RD;
                    end
                end
            end
            default: n_state = rps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_samp.valid && i_samp.ready) begin
            r_row  <= i_samp.row[CW-1:0];
            r_col  <= i_samp.col[CW-1:0];
            r_re   <= i_samp.real_part[SAMPLE_WIDTH-1:0];
            r_im   <= i_samp.imag_part[SAMPLE_WIDTH-1:0];
            r_last <= i_samp.last_sample;
            r_win  <= (i_samp.row < w_hs) && (i_samp.col < w_hs);
        end
        if (r_state == rps_pkg::S_SQUARE) begin
            r_x   <= w_r2[2*CW:1];
            r_pow <= PW'($unsigned(w_re2)) + PW'($unsigned(w_im2));
        end
        if (r_state == rps_pkg::S_ROOT && w_root_done) begin
            r_bin <= w_root_ext[BW-1:0];
        end
        if (r_state == rps_pkg::S_EMIT_GO) begin
            r_cnt_zero <= (w_cnt == '0);
        end
        if (r_state == rps_pkg::S_EMIT_DIV && w_div_done) begin
            r_avg <= r_cnt_zero ? '0 : w_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
            r_k   <= '0;
        end else begin
            if (w_clear) begin
                r_ovf <= 1'b0;
            end else if (r_state == rps_pkg::S_ROOT && w_root_done && w_root_out) begin
                r_ovf <= 1'b1;
            end
            if (r_state == rps_pkg::S_EMIT_OUT && o_bins.ready) begin
                r_k <= w_last_k ? '0 : r_k + 1'b1;
            end
        end
    end

    assign o_bins.bin_index     = rps_pkg::BIN_IDX_W'(r_k);
    assign o_bins.average_power = r_avg;
    assign o_bins.last_bin      = w_last_k;
    assign o_bins.overflow_seen = r_ovf;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bins.valid |-> !i_samp.ready)
        else $error("result offered while a sample is taken");
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (NBW'(r_bin) < w_nb))
        else $error("bin write beyond bins in use");
    a_flag_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bins.valid && o_bins.ready && o_bins.last_bin) |=> (!r_ovf && r_k == '0))
        else $error("frame state not cleared after final bin");
    a_read_before_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> $past(w_rd_en))
        else $error("bin write without preceding read");
endmodule
`default_nettype wire

// File: rtl/rps_isqrt.sv
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rps_isqrt #(
    parameter int ROOT_W = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [2*ROOT_W-1:0]   i_x,
    output logic                       o_done,
    output logic [ROOT_W-1:0]          o_root
);
    localparam int XW = 2 * ROOT_W;
    localparam int SW = $clog2(ROOT_W + 1);

    logic [XW-1:0] r_x, r_res, r_bit;
    logic [SW-1:0] r_step;
    logic          r_busy, r_done;
    logic [XW-1:0] w_sum;

    assign w_sum = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_x    <= i_x;
                r_res  <= '0;
                r_bit  <= XW'(1) << (XW - 2);
            end else if (r_busy) begin
                if (r_x >= w_sum) begin
                    r_x   <= r_x - w_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_step == SW'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];
endmodule
`default_nettype wire

// File: rtl/rps_divider.sv
// Restoring divider, one quotient bit per cycle, saturated quotient.
`timescale 1ns / 1ps
`default_nettype none
module rps_divider #(
    parameter int NUM_W = rps_pkg::SUM_W,
    parameter int DEN_W = rps_pkg::CNT_W,
    parameter int QUO_W = rps_pkg::AVG_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic                   o_done,
    output logic [QUO_W-1:0]       o_quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num, r_quo;
    logic [DEN_W-1:0] r_den, r_rem;
    logic [CW-1:0]    r_step;
    logic             r_busy, r_done;
    logic [DEN_W:0]   w_trial, w_diff;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= w_diff[DEN_W-1:0];
                    r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[DEN_W-1:0];
                    r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                end
                if (r_step == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = (|r_quo[NUM_W-1:QUO_W]) ? '1 : r_quo[QUO_W-1:0];
endmodule
`default_nettype wire
